// ----- hdl/kbt_pkg.sv -----
// Shared types, constants and fixed-point helpers for the box tracker.
package kbt_pkg;

  localparam int KBT_FRAC_BITS = 16;
  localparam int KBT_NS        = 8;
  localparam int KBT_COV_DEPTH = KBT_NS * KBT_NS;
  localparam int KBT_DW        = 32;
  localparam int KBT_CFG_DW    = 32;

  localparam logic [15:0] PN_RESET = 16'd66;
  localparam logic [19:0] MN_RESET = 20'd13107;
  localparam logic [19:0] IC_RESET = 20'd65536;
  // covariance diagonal right after reset
  localparam logic [31:0] COV_RESET_DIAG = 32'd65536;

  localparam logic signed [31:0] Q_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN  = 32'sh80000000;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_PREDICT = 2'd1,
    MODE_UPDATE  = 2'd2
  } kbt_mode_t;

  typedef enum logic [1:0] {
    CFG_PROCESS_NOISE = 2'd0,
    CFG_MEAS_NOISE    = 2'd1,
    CFG_INIT_COV      = 2'd2
  } kbt_cfg_idx_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic signed [31:0] box_width;
    logic signed [31:0] box_height;
    logic               scale_valid;
  } kbt_in_t;

  typedef struct packed {
    logic signed [31:0] pred_left;
    logic signed [31:0] pred_top;
    logic signed [31:0] pred_width;
    logic signed [31:0] pred_height;
    logic               ratio_fault;
  } kbt_out_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [31:0] den;
  } kbt_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } kbt_div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > SAT_HI) return Q_MAX;
    if (v < SAT_LO) return Q_MIN;
    return v[31:0];
  endfunction

  // x/2 truncated toward zero
  function automatic logic signed [31:0] half(input logic signed [31:0] x);
    logic signed [32:0] t;
    t = {x[31], x} + {32'd0, x[31]};
    return t[32:1];
  endfunction

  function automatic logic [31:0] absu(input logic signed [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

endpackage

// ----- hdl/kbt_ram.sv -----
// Simple dual-port RAM, one write port, one registered read port.
module kbt_ram #(
  parameter int WIDTH = kbt_pkg::KBT_DW,
  parameter int DEPTH = kbt_pkg::KBT_COV_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/kbt_div.sv -----
// Radix-2 signed divider, 64-bit numerator by 32-bit divisor, saturated 32-bit quotient.
module kbt_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kbt_pkg::kbt_div_req_t req,
  output kbt_pkg::kbt_div_rsp_t rsp
);
  import kbt_pkg::*;

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN, DV_DONE} dv_state_t;

  dv_state_t          st_r;
  logic [31:0]        rem_r;
  logic [31:0]        lo_r;
  logic [31:0]        q_r;
  logic [31:0]        den_r;
  logic               neg_r;
  logic [4:0]         cnt_r;
  logic signed [31:0] quo_r;

  logic [63:0] nmag;
  logic [31:0] dmag;
  logic [32:0] rem2;
  logic        ge;
  logic [32:0] rem_sub;

  assign nmag    = req.num[63] ? (64'd0 - req.num) : req.num;
  assign dmag    = absu(req.den);
  assign rem2    = {rem_r, lo_r[31]};
  assign ge      = rem2 >= {1'b0, den_r};
  assign rem_sub = ge ? (rem2 - {1'b0, den_r}) : rem2;

  assign rsp.done = (st_r == DV_DONE);
  assign rsp.quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DV_IDLE;
    end else begin
      case (st_r)
        DV_IDLE: begin
          if (req.start) begin
            den_r <= dmag;
            neg_r <= req.num[63] ^ req.den[31];
            // quotient of 2^32 or more always saturates
            if (nmag[63:32] >= dmag) begin
              quo_r <= (req.num[63] ^ req.den[31]) ? Q_MIN : Q_MAX;
              st_r  <= DV_DONE;
            end else begin
              rem_r <= nmag[63:32];
              lo_r  <= nmag[31:0];
              q_r   <= '0;
              cnt_r <= '0;
              st_r  <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          rem_r <= rem_sub[31:0];
          lo_r  <= {lo_r[30:0], 1'b0};
          q_r   <= {q_r[30:0], ge};
          cnt_r <= cnt_r + 5'd1;
          if (&cnt_r) begin
            st_r <= DV_FIN;
          end
        end
        DV_FIN: begin
          if (neg_r) begin
            quo_r <= (q_r > 32'h80000000) ? Q_MIN : (32'd0 - q_r);
          end else begin
            quo_r <= q_r[31] ? Q_MAX : q_r;
          end
          st_r <= DV_DONE;
        end
        DV_DONE: begin
          st_r <= DV_IDLE;
        end
        default: begin
          st_r <= DV_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/kalman_box_tracker_8state.sv -----
// Box tracker, 8-state constant-velocity Kalman filter in signed fixed point. Corrected and
// predicted covariance each live in a 64-word RAM; a sequencer walks them one word at a time
// through a single 32x32 multiplier and a shared radix-2 divider.
// After reset a clearing pass runs before the first word is taken. Init writes the
// corrected covariance, predict walks every covariance entry and then does one ratio
// division, and a full update spends most of its time in the
// pivot-row divisions and the covariance write-back. Mode 3 is accepted and ignored.
// A finished predict word waits in the output register while the next word is accepted.
module kalman_box_tracker_8state #(
  parameter int FRAC_BITS = kbt_pkg::KBT_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  kbt_pkg::kbt_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output kbt_pkg::kbt_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [kbt_pkg::KBT_CFG_DW-1:0] cfg_data
);
  import kbt_pkg::*;

  localparam logic signed [31:0] ONE = 32'(64'sd1 <<< FRAC_BITS);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_INIT_W,
    ST_PR_RD, ST_PR_FIN, ST_PR_WR, ST_PR_MUL, ST_PR_DIVS, ST_PR_DIVW, ST_PUB,
    ST_U_SRD, ST_U_SWR, ST_U_PIV0, ST_U_PIV, ST_U_PCHK, ST_U_PVL,
    ST_U_NRM, ST_U_NRMW, ST_U_ELF, ST_U_ELM, ST_U_ELS,
    ST_MAC_RD, ST_MAC_MUL, ST_MAC_ACC, ST_MAC_WR, ST_MAC_PB,
    ST_COPY_RD, ST_COPY_WR, ST_U_END
  } state_t;

  typedef enum logic [1:0] {OP_GAIN, OP_XUPD, OP_PUPD} mac_op_t;

  state_t  state_r;
  mac_op_t op_r;

  logic [15:0] pn_r;
  logic [19:0] mn_r;
  logic [19:0] ic_r;

  logic signed [31:0] cs_r   [8];
  logic signed [31:0] ps_r   [8];
  logic signed [31:0] z_r    [4];
  logic signed [31:0] s_r    [4][8];
  logic signed [31:0] prow_r [8];
  logic signed [31:0] gain_r [8][4];
  logic [1:0]         perm_r [4];
  logic signed [31:0] rel_w_r, rel_h_r, keep_w_r, keep_h_r;
  logic signed [31:0] piv_r, f_r, xr_r, b_r, h_r;
  logic [31:0]        best_r;
  logic [1:0]         p_r, c_r, t_r;
  logic [2:0]         i_r, j_r;
  logic [5:0]         e_r;
  logic               full_r, ld_r, fault_r;
  logic signed [34:0] acc_r;
  logic signed [63:0] mul_r;
  logic               out_valid_r;
  kbt_out_t           out_data_r;

  // RAM ports
  logic        covc_we, covp_we;
  logic [5:0]  covc_waddr, covp_waddr, covc_raddr, covp_raddr;
  logic [31:0] covc_wdata, covp_wdata, covc_rdata, covp_rdata;

  kbt_div_req_t div_req;
  kbt_div_rsp_t div_rsp;

  kbt_ram #(.WIDTH(KBT_DW), .DEPTH(KBT_COV_DEPTH)) u_covc (
    .clk(clk), .we(covc_we), .waddr(covc_waddr), .wdata(covc_wdata),
    .raddr(covc_raddr), .rdata(covc_rdata)
  );

  kbt_ram #(.WIDTH(KBT_DW), .DEPTH(KBT_COV_DEPTH)) u_covp (
    .clk(clk), .we(covp_we), .waddr(covp_waddr), .wdata(covp_wdata),
    .raddr(covp_raddr), .rdata(covp_rdata)
  );

  kbt_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  logic [1:0]         mlast;
  logic [2:0]         jlast, mbase;
  logic               accept;
  logic signed [31:0] cx, cy;
  logic [1:0]         s_ridx;
  logic [2:0]         s_col;
  logic signed [31:0] srd;
  logic signed [31:0] innov;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] qm;
  logic [5:0]         pr_addr;
  logic               pr_term;
  logic               i_last, c_last;

  assign mlast    = full_r ? 2'd3 : 2'd1;
  assign jlast    = full_r ? 3'd7 : 3'd3;
  assign mbase    = full_r ? 3'd4 : 3'd2;
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cx = sat32(64'(in_data.box_left) + 64'(half(in_data.box_width)));
  assign cy = sat32(64'(in_data.box_top) + 64'(half(in_data.box_height)));

  assign i_last = (i_r[1:0] == mlast);
  assign c_last = (c_r == mlast);

  // predict term t: bit 0 adds the velocity row, bit 1 the velocity column
  assign pr_addr = {e_r[5] | t_r[0], e_r[4:3], e_r[2] | t_r[1], e_r[1:0]};
  assign pr_term = !(t_r[0] & e_r[5]) && !(t_r[1] & e_r[2]);

  // single read address into the elimination matrix
  always_comb begin
    case (state_r)
      ST_U_PIV, ST_U_ELF, ST_U_ELS: s_ridx = i_r[1:0];
      ST_MAC_RD:                    s_ridx = t_r;
      default:                      s_ridx = c_r;
    endcase
    case (state_r)
      ST_U_PIV0, ST_U_PIV, ST_U_PVL, ST_U_ELF: s_col = {1'b0, c_r};
      ST_MAC_RD:                               s_col = mbase + j_r;
      default:                                 s_col = j_r;
    endcase
  end

  assign srd   = s_r[perm_r[s_ridx]][s_col];
  assign innov = sat32(64'(z_r[t_r]) - 64'(ps_r[{1'b0, t_r}]));

  always_comb begin
    case (state_r)
      ST_PR_MUL: begin
        mul_a = ps_r[2];
        mul_b = rel_h_r;
      end
      ST_U_ELM: begin
        mul_a = f_r;
        mul_b = prow_r[j_r];
      end
      default: begin
        mul_a = (op_r == OP_XUPD) ? xr_r : signed'(covp_rdata);
        mul_b = b_r;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);
  assign qm   = sat32(mul_r >>> FRAC_BITS);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = mul_r;
    div_req.den   = rel_w_r;
    if (state_r == ST_PR_DIVS) begin
      div_req.start = 1'b1;
    end else if (state_r == ST_U_NRM) begin
      div_req.start = (srd != 32'sd0);
      div_req.num   = 64'(srd) <<< FRAC_BITS;
      div_req.den   = piv_r;
    end
  end

  always_comb begin
    covc_we    = 1'b0;
    covc_waddr = e_r;
    covc_wdata = '0;
    covp_we    = 1'b0;
    covp_waddr = e_r;
    covp_wdata = '0;
    covc_raddr = pr_addr;
    covp_raddr = e_r;
    case (state_r)
      ST_CLR: begin
        covc_we    = 1'b1;
        covc_wdata = (e_r[5:3] == e_r[2:0]) ? COV_RESET_DIAG : 32'd0;
        covp_we    = 1'b1;
      end
      ST_INIT_W: begin
        covc_we    = 1'b1;
        covc_wdata = (e_r[5:3] == e_r[2:0]) ? {12'd0, ic_r} : 32'd0;
      end
      ST_PR_WR: begin
        covp_we    = 1'b1;
        covp_wdata = sat32(64'(acc_r) +
                           ((e_r[5:3] == e_r[2:0]) ? signed'({48'd0, pn_r}) : 64'sd0));
      end
      ST_U_SRD:  covp_raddr = {i_r, j_r};
      ST_MAC_RD: covp_raddr = (op_r == OP_GAIN) ? {i_r, 1'b0, t_r} : {1'b0, t_r, j_r};
      ST_MAC_WR: covp_raddr = {i_r, j_r};
      ST_MAC_PB: begin
        covc_we    = 1'b1;
        covc_waddr = {i_r, j_r};
        covc_wdata = sat32(64'(signed'(covp_rdata)) - 64'(acc_r));
      end
      ST_COPY_WR: begin
        covc_we    = 1'b1;
        covc_wdata = covp_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      e_r         <= '0;
      ld_r        <= 1'b0;
      out_valid_r <= 1'b0;
      pn_r        <= PN_RESET;
      mn_r        <= MN_RESET;
      ic_r        <= IC_RESET;
      rel_w_r     <= '0;
      rel_h_r     <= '0;
      for (int k = 0; k < 8; k++) begin
        cs_r[k] <= '0;
        ps_r[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROCESS_NOISE: pn_r <= cfg_data[15:0];
          CFG_MEAS_NOISE:    mn_r <= cfg_data[19:0];
          CFG_INIT_COV:      ic_r <= cfg_data[19:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      ld_r <= 1'b0;
      if (ld_r) begin
        acc_r <= acc_r + 35'(signed'(covc_rdata));
      end

      case (state_r)
        ST_CLR: begin
          e_r <= e_r + 6'd1;
          if (&e_r) state_r <= ST_IDLE;
        end

        ST_IDLE: begin
          if (accept) begin
            case (in_data.mode)
              MODE_INIT: begin
                cs_r[0] <= cx;
                cs_r[1] <= cy;
                cs_r[2] <= in_data.box_width;
                cs_r[3] <= in_data.box_height;
                for (int k = 4; k < 8; k++) cs_r[k] <= '0;
                rel_w_r <= in_data.box_width;
                rel_h_r <= in_data.box_height;
                e_r     <= '0;
                state_r <= ST_INIT_W;
              end
              MODE_PREDICT: begin
                for (int k = 0; k < 4; k++) begin
                  ps_r[k]     <= sat32(64'(cs_r[k]) + 64'(cs_r[k+4]));
                  ps_r[k + 4] <= cs_r[k + 4];
                end
                e_r     <= '0;
                t_r     <= '0;
                acc_r   <= '0;
                state_r <= ST_PR_RD;
              end
              MODE_UPDATE: begin
                z_r[0]   <= cx;
                z_r[1]   <= cy;
                z_r[2]   <= in_data.box_width;
                z_r[3]   <= in_data.box_height;
                full_r   <= in_data.scale_valid;
                keep_w_r <= cs_r[2];
                keep_h_r <= cs_r[3];
                for (int k = 0; k < 4; k++) perm_r[k] <= 2'(k);
                i_r      <= '0;
                j_r      <= '0;
                state_r  <= ST_U_SRD;
              end
              default: ;
            endcase
          end
        end

        ST_INIT_W: begin
          e_r <= e_r + 6'd1;
          if (&e_r) state_r <= ST_IDLE;
        end

        // prediction: covariance entry sums up to four corrected entries
        ST_PR_RD: begin
          ld_r <= pr_term;
          t_r  <= t_r + 2'd1;
          if (&t_r) state_r <= ST_PR_FIN;
        end
        ST_PR_FIN: state_r <= ST_PR_WR;
        ST_PR_WR: begin
          acc_r <= '0;
          e_r   <= e_r + 6'd1;
          state_r <= (&e_r) ? ST_PR_MUL : ST_PR_RD;
        end
        ST_PR_MUL: begin
          if (rel_w_r == 32'sd0) begin
            h_r     <= Q_MAX;
            fault_r <= 1'b1;
            state_r <= ST_PUB;
          end else begin
            mul_r   <= prod;
            fault_r <= 1'b0;
            state_r <= ST_PR_DIVS;
          end
        end
        ST_PR_DIVS: state_r <= ST_PR_DIVW;
        ST_PR_DIVW: begin
          if (div_rsp.done) begin
            h_r     <= div_rsp.quo;
            state_r <= ST_PUB;
          end
        end
        ST_PUB: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.pred_left   <= sat32(64'(ps_r[0]) - 64'(half(ps_r[2])));
            out_data_r.pred_top    <= sat32(64'(ps_r[1]) - 64'(half(h_r)));
            out_data_r.pred_width  <= ps_r[2];
            out_data_r.pred_height <= h_r;
            out_data_r.ratio_fault <= fault_r;
            out_valid_r            <= 1'b1;
            state_r                <= ST_IDLE;
          end
        end

        // innovation covariance and identity side by side
        ST_U_SRD: state_r <= ST_U_SWR;
        ST_U_SWR: begin
          s_r[i_r[1:0]][j_r] <= sat32(64'(signed'(covp_rdata)) +
                                      ((i_r == j_r) ? signed'({44'd0, mn_r}) : 64'sd0));
          s_r[i_r[1:0]][mbase + j_r] <= (i_r == j_r) ? ONE : 32'sd0;
          if (j_r[1:0] == mlast) begin
            j_r <= '0;
            if (i_last) begin
              c_r     <= '0;
              state_r <= ST_U_PIV0;
            end else begin
              i_r     <= i_r + 3'd1;
              state_r <= ST_U_SRD;
            end
          end else begin
            j_r     <= j_r + 3'd1;
            state_r <= ST_U_SRD;
          end
        end

        ST_U_PIV0: begin
          p_r     <= c_r;
          best_r  <= absu(srd);
          i_r     <= {1'b0, c_r} + 3'd1;
          state_r <= c_last ? ST_U_PCHK : ST_U_PIV;
        end
        ST_U_PIV: begin
          if (absu(srd) > best_r) begin
            best_r <= absu(srd);
            p_r    <= i_r[1:0];
          end
          i_r <= i_r + 3'd1;
          if (i_last) state_r <= ST_U_PCHK;
        end
        ST_U_PCHK: begin
          if (best_r == 32'd0) begin
            // singular: prior goes through unchanged
            for (int k = 0; k < 8; k++) cs_r[k] <= ps_r[k];
            e_r     <= '0;
            state_r <= ST_COPY_RD;
          end else begin
            perm_r[p_r] <= perm_r[c_r];
            perm_r[c_r] <= perm_r[p_r];
            state_r     <= ST_U_PVL;
          end
        end
        ST_U_PVL: begin
          piv_r   <= srd;
          j_r     <= '0;
          state_r <= ST_U_NRM;
        end
        ST_U_NRM: begin
          if (srd == 32'sd0) begin
            prow_r[j_r] <= '0;
            if (j_r == jlast) begin
              i_r     <= '0;
              state_r <= ST_U_ELF;
            end else begin
              j_r <= j_r + 3'd1;
            end
          end else begin
            state_r <= ST_U_NRMW;
          end
        end
        ST_U_NRMW: begin
          if (div_rsp.done) begin
            s_r[perm_r[c_r]][j_r] <= div_rsp.quo;
            prow_r[j_r]           <= div_rsp.quo;
            if (j_r == jlast) begin
              i_r     <= '0;
              state_r <= ST_U_ELF;
            end else begin
              j_r     <= j_r + 3'd1;
              state_r <= ST_U_NRM;
            end
          end
        end
        ST_U_ELF: begin
          if (i_r[1:0] == c_r) begin
            if (i_last) begin
              if (c_last) begin
                op_r    <= OP_GAIN;
                i_r     <= '0;
                j_r     <= '0;
                t_r     <= '0;
                acc_r   <= '0;
                state_r <= ST_MAC_RD;
              end else begin
                c_r     <= c_r + 2'd1;
                state_r <= ST_U_PIV0;
              end
            end else begin
              i_r <= i_r + 3'd1;
            end
          end else begin
            f_r     <= srd;
            j_r     <= '0;
            state_r <= ST_U_ELM;
          end
        end
        ST_U_ELM: begin
          mul_r   <= prod;
          state_r <= ST_U_ELS;
        end
        ST_U_ELS: begin
          s_r[perm_r[i_r[1:0]]][j_r] <= sat32(64'(srd) - 64'(qm));
          if (j_r == jlast) begin
            if (i_last) begin
              if (c_last) begin
                op_r    <= OP_GAIN;
                i_r     <= '0;
                j_r     <= '0;
                t_r     <= '0;
                acc_r   <= '0;
                state_r <= ST_MAC_RD;
              end else begin
                c_r     <= c_r + 2'd1;
                state_r <= ST_U_PIV0;
              end
            end else begin
              i_r     <= i_r + 3'd1;
              state_r <= ST_U_ELF;
            end
          end else begin
            j_r     <= j_r + 3'd1;
            state_r <= ST_U_ELM;
          end
        end

        // gain, state and covariance correction share one multiply-accumulate loop
        ST_MAC_RD: begin
          case (op_r)
            OP_GAIN: b_r <= srd;
            OP_XUPD: begin
              xr_r <= gain_r[i_r][t_r];
              b_r  <= innov;
            end
            default: b_r <= gain_r[i_r][t_r];
          endcase
          state_r <= ST_MAC_MUL;
        end
        ST_MAC_MUL: begin
          mul_r   <= prod;
          state_r <= ST_MAC_ACC;
        end
        ST_MAC_ACC: begin
          acc_r <= acc_r + 35'(qm);
          if (t_r == mlast) begin
            t_r     <= '0;
            state_r <= ST_MAC_WR;
          end else begin
            t_r     <= t_r + 2'd1;
            state_r <= ST_MAC_RD;
          end
        end
        ST_MAC_WR: begin
          case (op_r)
            OP_GAIN: begin
              gain_r[i_r][j_r[1:0]] <= sat32(64'(acc_r));
              acc_r   <= '0;
              state_r <= ST_MAC_RD;
              if (j_r[1:0] == mlast) begin
                j_r <= '0;
                if (&i_r) begin
                  op_r <= OP_XUPD;
                  i_r  <= '0;
                end else begin
                  i_r <= i_r + 3'd1;
                end
              end else begin
                j_r <= j_r + 3'd1;
              end
            end
            OP_XUPD: begin
              cs_r[i_r] <= sat32(64'(ps_r[i_r]) + 64'(acc_r));
              acc_r     <= '0;
              state_r   <= ST_MAC_RD;
              if (&i_r) begin
                op_r <= OP_PUPD;
                i_r  <= '0;
                j_r  <= '0;
              end else begin
                i_r <= i_r + 3'd1;
              end
            end
            default: state_r <= ST_MAC_PB;
          endcase
        end
        ST_MAC_PB: begin
          acc_r <= '0;
          j_r   <= j_r + 3'd1;
          if (&j_r) begin
            i_r <= i_r + 3'd1;
          end
          state_r <= (&{i_r, j_r}) ? ST_U_END : ST_MAC_RD;
        end

        ST_COPY_RD: state_r <= ST_COPY_WR;
        ST_COPY_WR: begin
          e_r     <= e_r + 6'd1;
          state_r <= (&e_r) ? ST_U_END : ST_COPY_RD;
        end

        ST_U_END: begin
          if (full_r) begin
            rel_w_r <= z_r[2];
            rel_h_r <= z_r[3];
          end else begin
            cs_r[2] <= keep_w_r;
            cs_r[3] <= keep_h_r;
            cs_r[6] <= '0;
            cs_r[7] <= '0;
          end
          state_r <= ST_IDLE;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
